// ===== sv/ames_pkg.sv =====
// ----------------------------------------------------------------------------
// ames_pkg
// Shared constants, codes and controller/datapath interface types for the
// adjacency matrix edge store.
// ----------------------------------------------------------------------------
package ames_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_BITS  = 16;

    // internal widths
    localparam int VW     = $clog2(MAX_VERTICES);       // vertex index
    localparam int NCNT_W = $clog2(MAX_VERTICES + 1);   // vertex / degree count
    localparam int ADDR_W = 2 * VW;                     // matrix entry address

    // port field widths
    localparam int FUNC_W   = 2;
    localparam int VIDX_W   = 4;
    localparam int WIN_W    = 16;
    localparam int WOUT_W   = 16;
    localparam int DEG_W    = 5;
    localparam int TOTAL_W  = 9;
    localparam int VCOUNT_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOTAL_W-1:0] CNT_MAX = '1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NBR    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IS_DIRECTED  = 1'd1;

    typedef struct packed {
        logic load;
        logic do_add;
        logic do_mirror;
        logic do_remove;
        logic rd_weight;
        logic deg_clr;
        logic deg_acc;
        logic scan_clr;
        logic scan_step;
        logic emit_single;
        logic emit_nb;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              err;
        logic              mirror;
        logic              scan_last;
        logic              cur_pres;
        logic              out_free;
        logic              nb_last;
        logic              deg_zero;
    } stat_t;

    typedef struct packed {
        logic               edge_present;
        logic [WOUT_W-1:0]  weight_out;
        logic [DEG_W-1:0]   degree;
        logic [VIDX_W-1:0]  neighbor_index;
        logic               neighbor_valid;
        logic [TOTAL_W-1:0] edge_total;
        logic               last;
        logic               error;
    } res_t;

endpackage

// ===== sv/adjacency_matrix_edge_store_unit.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_edge_store_unit
// Weighted graph store: presence-and-weight matrix with a running edge count.
// ----------------------------------------------------------------------------
// Takes one operation beat at a time (add, remove, query, list neighbors) and
// returns its result beats through an output register, so a new operation is
// taken while the last result is still waiting downstream. An add writes the
// undirected mirror entry in a separate step, since the weight memory has a
// single write port. Query scans the source row once for the degree; neighbor
// listing scans it once for the degree and, unless that is zero, once more up
// to the last neighbor to emit them. The row is scanned one entry per cycle,
// but the second scan holds on a present entry while a stall on m_tready
// keeps the output register full. Presence bits sit in flip-flops cleared at
// reset, so no clearing pass is needed after reset; weights of absent entries
// are never returned.
// ----------------------------------------------------------------------------
module adjacency_matrix_edge_store_unit
    import ames_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VCOUNT_W-1:0]  cfg_wdata,
    // operation beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // source_vertex[3:0], dest_vertex[7:4],
                                            // weight_in[23:8]
    input  logic [1:0]           s_tuser,   // func[1:0]
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // edge_present[0], weight_out[16:1],
                                            // degree[21:17], neighbor_index[25:22],
                                            // neighbor_valid[26], edge_total[35:27],
                                            // zero[39:36]
    output logic                 m_tlast,
    output logic                 m_tuser    // error
);

    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    ames_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ames_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_func   (s_tuser),
        .in_src    (s_tdata[3:0]),
        .in_dst    (s_tdata[7:4]),
        .in_weight (s_tdata[23:8]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = {4'b0000, res.edge_total, res.neighbor_valid, res.neighbor_index,
                      res.degree, res.weight_out, res.edge_present};
    assign m_tlast = res.last;
    assign m_tuser = res.error;

endmodule

// ===== sv/ames_ctrl.sv =====
// ----------------------------------------------------------------------------
// ames_ctrl
// Operation sequencer: range check, mirrored weight write, row scans and
// result emission.
// ----------------------------------------------------------------------------
module ames_ctrl
    import ames_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_MIRROR = 3'd2;
    localparam logic [2:0] ST_DEG    = 3'd3;
    localparam logic [2:0] ST_NB_CHK = 3'd4;
    localparam logic [2:0] ST_NB     = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.err) begin
                    state_next = ST_EMIT;
                end else begin
                    unique case (stat.func)
                        FUNC_ADD: begin
                            cmd.do_add = 1'b1;
                            state_next = stat.mirror ? ST_MIRROR : ST_EMIT;
                        end
                        FUNC_REMOVE: begin
                            cmd.do_remove = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        FUNC_QUERY: begin
                            cmd.rd_weight = 1'b1;
                            cmd.deg_clr   = 1'b1;
                            cmd.scan_clr  = 1'b1;
                            state_next    = ST_DEG;
                        end
                        default: begin
                            cmd.deg_clr  = 1'b1;
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_DEG;
                        end
                    endcase
                end
            end
            ST_MIRROR: begin
                cmd.do_mirror = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_DEG: begin
                cmd.scan_step = 1'b1;
                cmd.deg_acc   = 1'b1;
                if (stat.scan_last) begin
                    state_next = (stat.func == FUNC_QUERY) ? ST_EMIT : ST_NB_CHK;
                end
            end
            ST_NB_CHK: begin
                if (stat.deg_zero) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_NB;
                end
            end
            ST_NB: begin
                // hold on a present entry until the output register frees up
                if (stat.cur_pres) begin
                    if (stat.out_free) begin
                        cmd.emit_nb = 1'b1;
                        if (stat.nb_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            cmd.scan_step = 1'b1;
                        end
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_single = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ames_datapath.sv =====
// ----------------------------------------------------------------------------
// ames_datapath
// Presence bits, weight memory, edge counter, configuration registers,
// row scan counters and the output register.
// ----------------------------------------------------------------------------
module ames_datapath
    import ames_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VCOUNT_W-1:0]  cfg_wdata,
    input  logic [FUNC_W-1:0]    in_func,
    input  logic [VIDX_W-1:0]    in_src,
    input  logic [VIDX_W-1:0]    in_dst,
    input  logic [WIN_W-1:0]     in_weight,
    input  logic                 out_ready,
    output logic                 out_valid,
    output res_t                 out_res,
    input  cmd_t                 cmd,
    output stat_t                stat
);

    logic [VCOUNT_W-1:0]    vcount_reg;
    logic                   directed_reg;

    logic [FUNC_W-1:0]      op_func_reg;
    logic [VIDX_W-1:0]      op_src_reg;
    logic [VIDX_W-1:0]      op_dst_reg;
    logic [WEIGHT_BITS-1:0] op_w_reg;

    logic [MAX_VERTICES-1:0] pres_reg [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0]  wmem [MAX_VERTICES*MAX_VERTICES];
    logic [WEIGHT_BITS-1:0]  rdata_reg;

    logic [TOTAL_W-1:0] cnt_reg;
    logic [VW-1:0]      idx_reg;
    logic [NCNT_W-1:0]  deg_reg;
    logic [NCNT_W-1:0]  nbk_reg;

    logic out_valid_reg;
    res_t res_reg, res_next;

    logic [NCNT_W-1:0] n_act;
    logic [VW-1:0]     src_i, dst_i;
    logic              pres_sd;
    logic              cur_pres;
    logic              err;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    assign n_act = (int'(vcount_reg) > MAX_VERTICES) ? NCNT_W'(MAX_VERTICES)
                                                     : NCNT_W'(vcount_reg);
    assign src_i    = VW'(op_src_reg);
    assign dst_i    = VW'(op_dst_reg);
    assign pres_sd  = pres_reg[src_i][dst_i];
    assign cur_pres = pres_reg[src_i][idx_reg];
    assign err      = (32'(op_src_reg) >= 32'(n_act)) ||
                      ((op_func_reg != FUNC_NBR) && (32'(op_dst_reg) >= 32'(n_act)));
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        stat.func      = op_func_reg;
        stat.err       = err;
        stat.mirror    = !directed_reg && (src_i != dst_i);
        stat.scan_last = (NCNT_W'(idx_reg) == NCNT_W'(n_act - NCNT_W'(1)));
        stat.cur_pres  = cur_pres;
        stat.out_free  = out_free;
        stat.nb_last   = (NCNT_W'(nbk_reg + NCNT_W'(1)) == deg_reg);
        stat.deg_zero  = (deg_reg == '0);
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg   <= VCOUNT_W'(16);
            directed_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg   <= cfg_wdata;
                REG_IS_DIRECTED:  directed_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // captured operation
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_func_reg <= in_func;
            op_src_reg  <= in_src;
            op_dst_reg  <= in_dst;
            op_w_reg    <= WEIGHT_BITS'(in_weight);
        end
    end

    // presence bits and edge counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < MAX_VERTICES; r++) begin
                pres_reg[r] <= '0;
            end
            cnt_reg <= '0;
        end else if (cmd.do_add) begin
            if (!pres_sd && (cnt_reg < CNT_MAX)) begin
                cnt_reg <= cnt_reg + TOTAL_W'(1);
            end
            pres_reg[src_i][dst_i] <= 1'b1;
            if (!directed_reg) begin
                pres_reg[dst_i][src_i] <= 1'b1;
            end
        end else if (cmd.do_remove && pres_sd) begin
            pres_reg[src_i][dst_i] <= 1'b0;
            if (!directed_reg) begin
                pres_reg[dst_i][src_i] <= 1'b0;
            end
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - TOTAL_W'(1);
            end
        end
    end

    // weight memory: one write, one registered read
    assign wr_en   = cmd.do_add || cmd.do_mirror;
    assign wr_addr = cmd.do_mirror ? {dst_i, src_i} : {src_i, dst_i};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wmem[wr_addr] <= op_w_reg;
        end
        if (cmd.rd_weight) begin
            rdata_reg <= wmem[{src_i, dst_i}];
        end
    end

    // row scan
    always_ff @(posedge aclk) begin
        if (cmd.scan_clr) begin
            idx_reg <= '0;
            nbk_reg <= '0;
        end else begin
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + VW'(1);
            end
            if (cmd.emit_nb) begin
                nbk_reg <= nbk_reg + NCNT_W'(1);
            end
        end
        if (cmd.deg_clr) begin
            deg_reg <= '0;
        end else if (cmd.deg_acc) begin
            deg_reg <= deg_reg + NCNT_W'(cur_pres);
        end
    end

    // result assembly
    always_comb begin
        res_next            = '0;
        res_next.edge_total = cnt_reg;
        res_next.last       = 1'b1;
        if (cmd.emit_nb) begin
            res_next.degree         = DEG_W'(deg_reg);
            res_next.neighbor_index = VIDX_W'(idx_reg);
            res_next.neighbor_valid = 1'b1;
            res_next.last           = stat.nb_last;
        end else if (err) begin
            res_next.error = 1'b1;
        end else if (op_func_reg == FUNC_QUERY) begin
            res_next.edge_present = pres_sd;
            res_next.weight_out   = pres_sd ? WOUT_W'(rdata_reg) : '0;
            res_next.degree       = DEG_W'(deg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_single || cmd.emit_nb) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_single || cmd.emit_nb) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule
